>>> rtl/core/lbps_pkg.sv
// shared constants and controller/datapath command and status types
// for the least-busy port scheduler; no dependencies
package lbps_pkg;

  localparam int PORT_W  = 4;
  localparam int TIME_W  = 48;
  localparam int COUNT_W = 16;
  localparam int COST_W  = 8;
  localparam int PROD_W  = COST_W + COUNT_W;
  localparam int DELAY_W = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // register index, taken from paddr[2]
  localparam logic REG_READ_COST  = 1'b0;
  localparam logic REG_WRITE_COST = 1'b1;

  localparam logic [COST_W-1:0] COST_RESET = 8'd1;

  typedef struct packed {
    logic load;    // capture request
    logic scan;    // compare one port entry
    logic calc;    // raise start time, form cost product
    logic update;  // add, saturate, write back
    logic emit;    // load output register
  } cmd_t;

  typedef struct packed {
    logic zero;       // access count is zero
    logic scan_last;  // current scan entry is the last port of the bank
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

>>> rtl/core/lbps_if.sv
// request and response channel interfaces (valid/ready)
// depends on lbps_pkg
interface lbps_req_if;
  logic                        valid;
  logic                        ready;
  logic                        is_write;
  logic [lbps_pkg::COUNT_W-1:0] access_count;
  logic [lbps_pkg::TIME_W-1:0]  now_time;

  modport source (output valid, is_write, access_count, now_time, input ready);
  modport sink   (input valid, is_write, access_count, now_time, output ready);
endinterface

interface lbps_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lbps_pkg::DELAY_W-1:0] delay_cycles;
  logic [lbps_pkg::PORT_W-1:0]  port_index;

  modport source (output valid, delay_cycles, port_index, input ready);
  modport sink   (input valid, delay_cycles, port_index, output ready);
endinterface

>>> rtl/core/lbps_ctrl.sv
// sequencing state machine: idle, scan, calc, update, done
// depends on lbps_pkg
module lbps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbps_pkg::sts_t  sts,
  output lbps_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // zero count skips straight to the result
        if (sts.zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_last) state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/lbps_dp.sv
// datapath: port busy-until timers, min scan, booking arithmetic, output register
// depends on lbps_pkg
module lbps_dp #(
  parameter int READ_PORTS  = 4,
  parameter int WRITE_PORTS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lbps_pkg::cmd_t               cmd,
  output lbps_pkg::sts_t               sts,
  input  logic                         in_is_write,
  input  logic [lbps_pkg::COUNT_W-1:0] in_access_count,
  input  logic [lbps_pkg::TIME_W-1:0]  in_now_time,
  input  logic [lbps_pkg::COST_W-1:0]  read_cost,
  input  logic [lbps_pkg::COST_W-1:0]  write_cost,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lbps_pkg::DELAY_W-1:0] out_delay_cycles,
  output logic [lbps_pkg::PORT_W-1:0]  out_port_index
);

  localparam int TW = lbps_pkg::TIME_W;
  localparam int PW = lbps_pkg::PORT_W;

  logic [TW-1:0] rd_bank_r [READ_PORTS];
  logic [TW-1:0] wr_bank_r [WRITE_PORTS];

  logic                         is_write_r;
  logic [lbps_pkg::COUNT_W-1:0] count_r;
  logic [TW-1:0]                now_r;
  logic [lbps_pkg::COST_W-1:0]  cost_r;
  logic [PW-1:0]                scan_idx_r;
  logic [TW-1:0]                best_r;
  logic [PW-1:0]                best_idx_r;
  logic [TW-1:0]                start_r;
  logic [lbps_pkg::PROD_W-1:0]  prod_r;
  logic [TW-1:0]                end_r;
  logic                         out_valid_r;
  logic [lbps_pkg::DELAY_W-1:0] delay_r;
  logic [PW-1:0]                port_r;

  logic [TW-1:0] cur_val;
  logic [PW-1:0] last_idx;
  logic [TW:0]   sum;
  logic [TW-1:0] end_nxt;
  logic [TW-1:0] diff;
  logic [lbps_pkg::DELAY_W-1:0] delay_nxt;

  // entry under scan, one port per cycle
  always_comb begin
    cur_val = '0;
    if (is_write_r) begin
      for (int i = 0; i < WRITE_PORTS; i++) begin
        if (scan_idx_r == PW'(i)) cur_val = wr_bank_r[i];
      end
    end else begin
      for (int i = 0; i < READ_PORTS; i++) begin
        if (scan_idx_r == PW'(i)) cur_val = rd_bank_r[i];
      end
    end
  end

  assign last_idx = is_write_r ? PW'(WRITE_PORTS - 1) : PW'(READ_PORTS - 1);

  assign sum     = {1'b0, start_r} + {{(TW + 1 - lbps_pkg::PROD_W){1'b0}}, prod_r};
  assign end_nxt = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  assign diff      = end_r - now_r;
  assign delay_nxt = (|diff[TW-1:lbps_pkg::DELAY_W]) ? {lbps_pkg::DELAY_W{1'b1}}
                                                    : diff[lbps_pkg::DELAY_W-1:0];

  assign sts.zero      = (count_r == '0);
  assign sts.scan_last = (scan_idx_r == last_idx);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write_r <= in_is_write;
      count_r    <= in_access_count;
      now_r      <= in_now_time;
      cost_r     <= in_is_write ? write_cost : read_cost;
      scan_idx_r <= '0;
    end
    if (cmd.scan) begin
      // strict less-than keeps the lowest index on ties
      if (scan_idx_r == '0 || cur_val < best_r) begin
        best_r     <= cur_val;
        best_idx_r <= scan_idx_r;
      end
      scan_idx_r <= scan_idx_r + PW'(1);
    end
    if (cmd.calc) begin
      start_r <= (best_r < now_r) ? now_r : best_r;
      prod_r  <= cost_r * count_r;
    end
    if (cmd.update) begin
      end_r <= end_nxt;
    end
    if (cmd.emit) begin
      delay_r <= sts.zero ? '0 : delay_nxt;
      port_r  <= sts.zero ? '0 : best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < READ_PORTS; i++) rd_bank_r[i] <= '0;
      for (int i = 0; i < WRITE_PORTS; i++) wr_bank_r[i] <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < READ_PORTS; i++) begin
        if (!is_write_r && best_idx_r == PW'(i)) rd_bank_r[i] <= end_nxt;
      end
      for (int i = 0; i < WRITE_PORTS; i++) begin
        if (is_write_r && best_idx_r == PW'(i)) wr_bank_r[i] <= end_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_delay_cycles = delay_r;
  assign out_port_index   = port_r;

endmodule

>>> rtl/core/least_busy_port_scheduler_top.sv
// least-busy port scheduler top: APB-style cost registers, controller, datapath
// a request is captured, then the bank's busy-until timers are scanned one entry per cycle,
// then calc and update run and the result is loaded into the output register in the done state;
// a zero count skips the entry scan, calc and update; done waits while the output register is full;
// the next request is taken once the result sits in the output register
// reset clears all timers to 0 and both costs to 1
module least_busy_port_scheduler_top #(
  parameter int READ_PORTS  = 4,
  parameter int WRITE_PORTS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lbps_req_if.sink                    in_ch,
  lbps_rsp_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbps_pkg::ADDR_W-1:0] paddr,
  input  logic [lbps_pkg::DATA_W-1:0] pwdata,
  output logic [lbps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [lbps_pkg::COST_W-1:0] read_cost_r;
  logic [lbps_pkg::COST_W-1:0] write_cost_r;
  logic                        cfg_wr;

  lbps_pkg::cmd_t cmd;
  lbps_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_cost_r  <= lbps_pkg::COST_RESET;
      write_cost_r <= lbps_pkg::COST_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lbps_pkg::REG_READ_COST) begin
        read_cost_r <= pwdata[lbps_pkg::COST_W-1:0];
      end else begin
        write_cost_r <= pwdata[lbps_pkg::COST_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      lbps_pkg::REG_READ_COST:  prdata[lbps_pkg::COST_W-1:0] = read_cost_r;
      lbps_pkg::REG_WRITE_COST: prdata[lbps_pkg::COST_W-1:0] = write_cost_r;
      default:                  prdata = '0;
    endcase
  end

  lbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbps_dp #(
    .READ_PORTS  (READ_PORTS),
    .WRITE_PORTS (WRITE_PORTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_is_write      (in_ch.is_write),
    .in_access_count  (in_ch.access_count),
    .in_now_time      (in_ch.now_time),
    .read_cost        (read_cost_r),
    .write_cost       (write_cost_r),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_delay_cycles (out_ch.delay_cycles),
    .out_port_index   (out_ch.port_index)
  );

endmodule
